// ----- hdl/bcdce_pkg.sv -----
// Package for the BCD clock field editor: request and position codes,
// register addresses, result struct and the BCD stepping functions.
// Depends on nothing.
package bcdce_pkg;

  // Request codes
  typedef enum logic [1:0] {
    REQ_LEFT  = 2'd0,
    REQ_RIGHT = 2'd1,
    REQ_INC   = 2'd2,
    REQ_DEC   = 2'd3
  } req_e;

  // Cursor positions around the ring
  typedef enum logic [3:0] {
    POS_HOME    = 4'd0,
    POS_YEAR    = 4'd1,
    POS_MONTH   = 4'd2,
    POS_DATE    = 4'd3,
    POS_WEEKDAY = 4'd4,
    POS_AMPM    = 4'd5,
    POS_HOUR    = 4'd6,
    POS_MINUTE  = 4'd7,
    POS_SECOND  = 4'd8
  } pos_e;

  // Clock register addresses
  localparam logic [2:0] ADDR_SECOND  = 3'd0;
  localparam logic [2:0] ADDR_MINUTE  = 3'd1;
  localparam logic [2:0] ADDR_HOUR    = 3'd2;
  localparam logic [2:0] ADDR_WEEKDAY = 3'd3;
  localparam logic [2:0] ADDR_DATE    = 3'd4;
  localparam logic [2:0] ADDR_MONTH   = 3'd5;
  localparam logic [2:0] ADDR_YEAR    = 3'd6;

  // Field limits and bit masks
  localparam logic [7:0] YEAR_MAX   = 8'h99;
  localparam logic [7:0] MONTH_MAX  = 8'h12;
  localparam logic [7:0] DATE_MAX   = 8'h31;
  localparam logic [7:0] SEXA_MAX   = 8'h59;
  localparam logic [7:0] WDAY_MAX   = 8'h07;
  localparam logic [7:0] ZERO_MIN   = 8'h00;
  localparam logic [7:0] ONE_MIN    = 8'h01;
  localparam logic [7:0] HOUR_MAX   = 8'h12;
  localparam logic [7:0] DIGIT_MASK = 8'h1F;
  localparam logic [7:0] HIGH_MASK  = 8'hE0;
  localparam logic [7:0] PM_BIT     = 8'h20;
  localparam logic [7:0] MODE12_BIT = 8'h40;

  // Reciprocal of ten for an 8-bit dividend: q = (v * 205) >> 11
  localparam logic [15:0] RECIP10       = 16'd205;
  localparam int          RECIP10_SHIFT = 11;

  // One result word
  typedef struct packed {
    logic [3:0] cursor_pos;
    logic       write_enable;
    logic [2:0] reg_address;
    logic [7:0] write_value;
  } result_t;

  // Convert to binary, step by one with 8-bit wrap, convert back truncated
  function automatic logic [7:0] bcd_step(input logic [7:0] b, input logic up);
    logic [7:0]  v;
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    v    = 8'(({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]});
    v    = up ? 8'(v + 8'd1) : 8'(v - 8'd1);
    prod = 16'(v) * RECIP10;
    q    = 5'(prod >> RECIP10_SHIFT);
    r    = 8'(v - 8'(8'(q) * 8'd10));
    return 8'(8'({q, 4'b0000}) + r);
  endfunction

  // BCD step with wrap between lo and hi
  function automatic logic [7:0] wrap_step(input logic [7:0] b, input logic up,
                                           input logic [7:0] lo, input logic [7:0] hi);
    if (up) begin
      return (b == hi) ? lo : bcd_step(b, 1'b1);
    end else begin
      return (b == lo) ? hi : bcd_step(b, 1'b0);
    end
  endfunction

  // Hour digits step 01..12, upper bits kept, 12-hour mode bit set
  function automatic logic [7:0] hour_step(input logic [7:0] b, input logic up);
    logic [7:0] digits;
    logic [7:0] nd;
    digits = b & DIGIT_MASK;
    if (up) begin
      nd = (digits == HOUR_MAX) ? ONE_MIN : (bcd_step(digits, 1'b1) & DIGIT_MASK);
    end else begin
      nd = (digits == ONE_MIN) ? HOUR_MAX : (bcd_step(digits, 1'b0) & DIGIT_MASK);
    end
    return (b & HIGH_MASK) | MODE12_BIT | nd;
  endfunction

  // Weekday steps in binary over 1..7
  function automatic logic [7:0] wday_step(input logic [7:0] b, input logic up);
    if (up) begin
      return (b == WDAY_MAX) ? ONE_MIN : 8'(b + 8'd1);
    end else begin
      return (b == ONE_MIN) ? WDAY_MAX : 8'(b - 8'd1);
    end
  endfunction

endpackage

// ----- hdl/bcdce_if.sv -----
// Valid/ready channel interfaces for the BCD clock field editor.
// Depends on nothing.
interface bcdce_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] field_now;

  modport source (output valid, output req_type, output field_now, input ready);
  modport sink   (input valid, input req_type, input field_now, output ready);
endinterface

interface bcdce_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] cursor_pos;
  logic       write_enable;
  logic [2:0] reg_address;
  logic [7:0] write_value;

  modport source (output valid, output cursor_pos, output write_enable,
                  output reg_address, output write_value, input ready);
  modport sink   (input valid, input cursor_pos, input write_enable,
                  input reg_address, input write_value, output ready);
endinterface

// ----- hdl/bcdce_step.sv -----
// Combinational step of the editor: moves the cursor or computes the new
// register byte for the selected field. Depends on bcdce_pkg.
module bcdce_step (
  input  logic [3:0]        cursor_i,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        field_now_i,
  output bcdce_pkg::result_t result_o
);
  import bcdce_pkg::*;

  pos_e       cur;
  req_e       req;
  logic       up;
  logic [3:0] next_pos;
  logic       we;
  logic [2:0] addr;
  logic [7:0] val;

  // Treat an out-of-ring cursor as home
  assign cur = (cursor_i > POS_SECOND) ? POS_HOME : pos_e'(cursor_i);
  assign req = req_e'(req_type_i);
  assign up  = (req == REQ_INC);

  // Move the cursor
  always_comb begin
    next_pos = cur;
    unique case (req)
      REQ_LEFT:  next_pos = (cur == POS_HOME) ? POS_SECOND : 4'(cur - 4'd1);
      REQ_RIGHT: next_pos = (cur == POS_SECOND) ? POS_HOME : 4'(cur + 4'd1);
      REQ_INC, REQ_DEC: next_pos = cur;
      default:   next_pos = cur;
    endcase
  end

  // Compute the field write
  always_comb begin
    we   = 1'b0;
    addr = ADDR_SECOND;
    val  = 8'h00;
    if (req == REQ_INC || req == REQ_DEC) begin
      we = 1'b1;
      unique case (cur)
        POS_YEAR: begin
          addr = ADDR_YEAR;
          val  = wrap_step(field_now_i, up, ZERO_MIN, YEAR_MAX);
        end
        POS_MONTH: begin
          addr = ADDR_MONTH;
          val  = wrap_step(field_now_i, up, ONE_MIN, MONTH_MAX);
        end
        POS_DATE: begin
          addr = ADDR_DATE;
          val  = wrap_step(field_now_i, up, ONE_MIN, DATE_MAX);
        end
        POS_WEEKDAY: begin
          addr = ADDR_WEEKDAY;
          val  = wday_step(field_now_i, up);
        end
        POS_AMPM: begin
          addr = ADDR_HOUR;
          val  = field_now_i ^ PM_BIT;
        end
        POS_HOUR: begin
          addr = ADDR_HOUR;
          val  = hour_step(field_now_i, up);
        end
        POS_MINUTE: begin
          addr = ADDR_MINUTE;
          val  = wrap_step(field_now_i, up, ZERO_MIN, SEXA_MAX);
        end
        POS_SECOND: begin
          addr = ADDR_SECOND;
          val  = wrap_step(field_now_i, up, ZERO_MIN, SEXA_MAX);
        end
        default: begin
          // Home: nothing to write
          we = 1'b0;
        end
      endcase
    end
  end

  assign result_o = '{cursor_pos: next_pos, write_enable: we,
                      reg_address: addr, write_value: val};

endmodule

// ----- hdl/bcd_clock_field_editor.sv -----
// Top level of the BCD clock field editor: input register, step logic and
// result register. Depends on bcdce_pkg, bcdce_if and bcdce_step.

// Each accepted request word gives one result word, which passes through
// the input register and then the result register. A new request is
// taken every cycle as long as the result side keeps draining; the cursor
// register is updated as a request leaves the input register, so back-to-back
// moves and edits see each other's cursor. The editor powers up at home,
// where increment and decrement give a result with write_enable low.
module bcd_clock_field_editor (
  input  logic clk_i,
  input  logic rst_ni,
  bcdce_req_if.sink   req_i,
  bcdce_res_if.source res_o
);
  import bcdce_pkg::*;

  logic       in_valid_q;
  logic [1:0] req_type_q;
  logic [7:0] field_now_q;
  logic [3:0] cursor_q;
  logic [3:0] cursor_d;
  logic       out_valid_q;
  result_t    result_q;
  result_t    result_d;
  logic       out_free;
  logic       adv;
  logic       take;

  // Handshake: result stage frees when empty or taken; input stage advances into it
  assign out_free    = !out_valid_q || res_o.ready;
  assign adv         = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || adv;
  assign take        = req_i.valid && req_i.ready;

  bcdce_step u_step (
    .cursor_i    (cursor_q),
    .req_type_i  (req_type_q),
    .field_now_i (field_now_q),
    .result_o    (result_d)
  );

  assign cursor_d = adv ? result_d.cursor_pos : cursor_q;

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cursor_q    <= POS_HOME;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      cursor_q <= cursor_d;
    end
  end

  // Capture the request word
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_type_q  <= req_i.req_type;
      field_now_q <= req_i.field_now;
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= result_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.cursor_pos   = result_q.cursor_pos;
  assign res_o.write_enable = result_q.write_enable;
  assign res_o.reg_address  = result_q.reg_address;
  assign res_o.write_value  = result_q.write_value;

endmodule

// ----- hdl/bcdce_checker.sv -----
// Port-level checks for the BCD clock field editor, bound to the top level.
// Depends on bcdce_pkg.
module bcdce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [3:0] cursor_pos_i,
  input logic       write_enable_i,
  input logic [2:0] reg_address_i,
  input logic [7:0] write_value_i
);
  import bcdce_pkg::*;

  // Cursor stays on the ring
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> cursor_pos_i <= POS_SECOND)
    else $error("cursor left the ring");

  // A word without a write carries zero address and value
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !write_enable_i) |-> (reg_address_i == 3'd0 && write_value_i == 8'h00))
    else $error("non-write word carries data");

  // A write never targets home and never an address past the year
  a_write_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && write_enable_i) |->
      (cursor_pos_i != POS_HOME && reg_address_i <= ADDR_YEAR))
    else $error("write with bad target");

  // Hold a stalled result word
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      (res_valid_i && $stable(cursor_pos_i) && $stable(write_enable_i) &&
       $stable(reg_address_i) && $stable(write_value_i)))
    else $error("stalled result word changed");

endmodule

bind bcd_clock_field_editor bcdce_checker u_bcdce_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .cursor_pos_i   (res_o.cursor_pos),
  .write_enable_i (res_o.write_enable),
  .reg_address_i  (res_o.reg_address),
  .write_value_i  (res_o.write_value)
);

// ----- tb/tb_top.sv -----
// Testbench for bcd_clock_field_editor: directed and random request words
// against an in-bench model of the cursor ring and the BCD field steps.
// Depends on bcdce_pkg, bcdce_if and the editor RTL.
`timescale 1ns / 1ps

module tb_top;
  import bcdce_pkg::*;

  // Track the cursor, predict each result word and check it in arrival order
  class field_edit_board;
    pos_e    cursor;
    result_t pending_results[$];
    int      error_count;

    function new();
      cursor      = POS_HOME;
      error_count = 0;
    endfunction

    // Binary step of a BCD byte with 8-bit wrap, converted back truncated
    function automatic logic [7:0] bcd_bump(logic [7:0] b, bit up);
      int v;
      v = (int'(b[7:4]) * 10 + int'(b[3:0])) & 255;
      v = (up ? v + 1 : v - 1) & 255;
      return 8'((((v / 10) << 4) + (v % 10)) & 255);
    endfunction

    function automatic logic [7:0] ranged_bump(logic [7:0] b, bit up,
                                               logic [7:0] lo, logic [7:0] hi);
      if (up) return (b == hi) ? lo : bcd_bump(b, 1'b1);
      return (b == lo) ? hi : bcd_bump(b, 1'b0);
    endfunction

    // Hour digits wrap 01..12, top bits kept, 12-hour bit forced
    function automatic logic [7:0] hour_bump(logic [7:0] b, bit up);
      logic [7:0] digits;
      logic [7:0] nd;
      digits = b & 8'h1F;
      if (up) nd = (digits == 8'h12) ? 8'h01 : (bcd_bump(digits, 1'b1) & 8'h1F);
      else    nd = (digits == 8'h01) ? 8'h12 : (bcd_bump(digits, 1'b0) & 8'h1F);
      return (b & 8'hE0) | 8'h40 | nd;
    endfunction

    // Note an accepted request word and queue the result it must produce
    function void note_request(req_e req, logic [7:0] field);
      result_t exp;
      bit      up;
      up  = (req == REQ_INC);
      exp = '0;
      case (req)
        REQ_LEFT:  cursor = (cursor == POS_HOME) ? POS_SECOND : pos_e'(cursor - 4'd1);
        REQ_RIGHT: cursor = (cursor == POS_SECOND) ? POS_HOME : pos_e'(cursor + 4'd1);
        default: begin
          exp.write_enable = 1'b1;
          case (cursor)
            POS_YEAR: begin
              exp.reg_address = ADDR_YEAR;
              exp.write_value = ranged_bump(field, up, 8'h00, 8'h99);
            end
            POS_MONTH: begin
              exp.reg_address = ADDR_MONTH;
              exp.write_value = ranged_bump(field, up, 8'h01, 8'h12);
            end
            POS_DATE: begin
              exp.reg_address = ADDR_DATE;
              exp.write_value = ranged_bump(field, up, 8'h01, 8'h31);
            end
            POS_WEEKDAY: begin
              exp.reg_address = ADDR_WEEKDAY;
              if (up) exp.write_value = (field == 8'h07) ? 8'h01 : 8'(field + 8'd1);
              else    exp.write_value = (field == 8'h01) ? 8'h07 : 8'(field - 8'd1);
            end
            POS_AMPM: begin
              exp.reg_address = ADDR_HOUR;
              exp.write_value = field ^ 8'h20;
            end
            POS_HOUR: begin
              exp.reg_address = ADDR_HOUR;
              exp.write_value = hour_bump(field, up);
            end
            POS_MINUTE: begin
              exp.reg_address = ADDR_MINUTE;
              exp.write_value = ranged_bump(field, up, 8'h00, 8'h59);
            end
            POS_SECOND: begin
              exp.reg_address = ADDR_SECOND;
              exp.write_value = ranged_bump(field, up, 8'h00, 8'h59);
            end
            default: exp.write_enable = 1'b0;
          endcase
        end
      endcase
      exp.cursor_pos = cursor;
      pending_results.push_back(exp);
    endfunction

    function void report_mismatch(string name, int exp_val, int got_val);
      error_count++;
      if (error_count <= 40)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                 $time, name, exp_val, got_val);
    endfunction

    // Compare a result word against the oldest prediction
    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 40)
          $display("%0t: unexpected result word, expected none, got 0x%0h", $time, got);
        return;
      end
      exp = pending_results.pop_front();
      if (got.cursor_pos !== exp.cursor_pos)
        report_mismatch("cursor_pos", exp.cursor_pos, got.cursor_pos);
      if (got.write_enable !== exp.write_enable)
        report_mismatch("write_enable", exp.write_enable, got.write_enable);
      if (got.reg_address !== exp.reg_address)
        report_mismatch("reg_address", exp.reg_address, got.reg_address);
      if (got.write_value !== exp.write_value)
        report_mismatch("write_value", exp.write_value, got.write_value);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady;   // no idling on either side while set

  field_edit_board board;

  bcdce_req_if req_if ();
  bcdce_res_if res_if ();

  bcd_clock_field_editor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #10 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] to_bcd(int v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // Field byte for an edit: some raw noise, some wrap points, mostly legal values
  function automatic logic [7:0] pick_field(pos_e p);
    int         r;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] legal;
    logic [2:0] top;
    r   = $urandom_range(0, 9);
    top = 3'($urandom_range(0, 7));
    case (p)
      POS_YEAR:    begin lo = 8'h00; hi = 8'h99; legal = to_bcd($urandom_range(0, 99)); end
      POS_MONTH:   begin lo = 8'h01; hi = 8'h12; legal = to_bcd($urandom_range(1, 12)); end
      POS_DATE:    begin lo = 8'h01; hi = 8'h31; legal = to_bcd($urandom_range(1, 31)); end
      POS_WEEKDAY: begin lo = 8'h01; hi = 8'h07; legal = 8'($urandom_range(1, 7)); end
      POS_HOUR, POS_AMPM: begin
        lo    = {top, 5'h01};
        hi    = {top, 5'h12};
        legal = {top, 5'(to_bcd($urandom_range(1, 12)))};
      end
      POS_MINUTE, POS_SECOND: begin
        lo = 8'h00; hi = 8'h59; legal = to_bcd($urandom_range(0, 59));
      end
      default:     begin lo = 8'h00; hi = 8'hFF; legal = 8'($urandom_range(0, 255)); end
    endcase
    if (r < 3) return 8'($urandom_range(0, 255));
    if (r == 3) return lo;
    if (r == 4) return hi;
    return legal;
  endfunction

  // Offer one request word after a random gap and hold it until taken
  task automatic send_word(req_e rq, logic [7:0] fv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= rq;
    req_if.field_now <= fv;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    board.note_request(rq, fv);
  endtask

  task automatic send_move(req_e rq);
    send_word(rq, 8'($urandom_range(0, 255)));
  endtask

  // Stimulus and end of run
  initial begin
    int   r;
    req_e rq;
    board            = new();
    steady           = 1'b0;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= REQ_LEFT;
    req_if.field_now <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Home: edits write nothing; left wraps to second
    send_word(REQ_INC, 8'h00);
    send_word(REQ_DEC, 8'hFF);
    send_move(REQ_LEFT);
    send_word(REQ_INC, 8'h59);
    send_word(REQ_DEC, 8'h00);
    // Minute with a non-BCD byte
    send_move(REQ_LEFT);
    send_word(REQ_INC, 8'h9A);
    // Hour wraps, top bits kept
    send_move(REQ_LEFT);
    send_word(REQ_INC, 8'h12);
    send_word(REQ_DEC, 8'hE1);
    send_word(REQ_INC, 8'hFF);
    // AM/PM toggle
    send_move(REQ_LEFT);
    send_word(REQ_INC, 8'h7F);
    // Weekday wrap and zero underflow
    send_move(REQ_LEFT);
    send_word(REQ_INC, 8'h07);
    send_word(REQ_DEC, 8'h00);
    // Date wraps
    send_move(REQ_LEFT);
    send_word(REQ_INC, 8'h31);
    send_word(REQ_DEC, 8'h01);
    // Month: zero byte decremented
    send_move(REQ_LEFT);
    send_word(REQ_DEC, 8'h00);
    // Year wrap, then right to month and left twice back home
    send_move(REQ_LEFT);
    send_word(REQ_INC, 8'h99);
    send_move(REQ_RIGHT);
    send_move(REQ_LEFT);
    send_move(REQ_LEFT);

    // Random walk over the ring, edits shaped by the current position
    for (int i = 0; i < 1500; i++) begin
      if ($urandom_range(0, 149) == 0) steady = ~steady;
      r = $urandom_range(0, 99);
      if (r < 15)      rq = REQ_LEFT;
      else if (r < 30) rq = REQ_RIGHT;
      else if (r < 65) rq = REQ_INC;
      else             rq = REQ_DEC;
      if (rq == REQ_LEFT || rq == REQ_RIGHT) send_move(rq);
      else send_word(rq, pick_field(board.cursor));
    end
    req_if.valid <= 1'b0;
    steady = 1'b0;

    // Drain, then settle
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.error_count == 0 && board.pending_results.size() == 0) begin
      $display("bcd_clock_field_editor test passed");
    end else begin
      $display("bcd_clock_field_editor test failed");
    end
    $finish;
  end

  // Result side: stall at random, sometimes for long stretches
  initial begin
    int stall_left;
    stall_left   = 0;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0 && !steady) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        stall_left = 0;
        if (!steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got.cursor_pos   = res_if.cursor_pos;
      got.write_enable = res_if.write_enable;
      got.reg_address  = res_if.reg_address;
      got.write_value  = res_if.write_value;
      board.check_result(got);
    end
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("bcd_clock_field_editor test failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bcdce_pkg.sv
hdl/bcdce_if.sv
hdl/bcdce_step.sv
hdl/bcd_clock_field_editor.sv
hdl/bcdce_checker.sv
tb/tb_top.sv
